### sv/gfg_pkg.sv
`default_nettype none
package gfg_pkg;

  // Fixed widths of the request and result words.
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 6;
  localparam int STEP_W = 32;
  // Width that holds any grid size up to the largest axis parameter (256).
  localparam int CMP_W  = 9;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SIZE_X     = 3'd0,
    CFG_SIZE_Y     = 3'd1,
    CFG_SIZE_Z     = 3'd2,
    CFG_INV_STEP_X = 3'd3,
    CFG_INV_STEP_Y = 3'd4,
    CFG_INV_STEP_Z = 3'd5
  } cfg_index_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_DIFF,
    BK_MUL,
    BK_SCALE,
    BK_SQUARE,
    BK_SQRT,
    BK_DONE
  } back_state_t;

  // Input word.
  typedef struct packed {
    logic                     req_type;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic [POS_W-1:0]         pos_z;
    logic signed [DATA_W-1:0] potential;
  } gfg_req_t;

  // Result word.
  typedef struct packed {
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
    logic [DATA_W-1:0]        field_magnitude;
    logic                     saturated;
  } gfg_res_t;

endpackage
`default_nettype wire

### sv/grid_field_gradient_3d.sv
// Loads can follow one per clock while the back end is idle.
// A query passes through the queue, the read state for the six registered
// sample reads, the difference, multiply and scale states for each axis, the
// square states, the two-bits-per-cycle square root and the done state.
// A query holds the back end until done. Synchronous active-high reset clears
// control state and configuration, not the sample store; results cannot stall.
`default_nettype none
module grid_field_gradient_3d import gfg_pkg::*; #(
  parameter int MAX_X        = 32,
  parameter int MAX_Y        = 32,
  parameter int MAX_Z        = 32,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire gfg_req_t          req,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic                   done,
  output gfg_res_t               res
);

  localparam int AW = $clog2(MAX_X * MAX_Y * MAX_Z);

  logic [SIZE_W-1:0]        size_x, size_y, size_z;
  logic [2:0][STEP_W-1:0]   inv_step;
  logic                     q_valid, q_ready, q_query;
  logic [2:0]               q_sh17;
  logic [5:0][AW-1:0]       q_addr;
  logic [SAMPLE_WIDTH-1:0]  q_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x   <= SIZE_W'(32);
      size_y   <= SIZE_W'(32);
      size_z   <= SIZE_W'(32);
      inv_step <= {3{STEP_W'(65536)}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_X:     size_x      <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:     size_y      <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:     size_z      <= cfg_data[SIZE_W-1:0];
        CFG_INV_STEP_X: inv_step[0] <= cfg_data;
        CFG_INV_STEP_Y: inv_step[1] <= cfg_data;
        CFG_INV_STEP_Z: inv_step[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gfg_front #(
    .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z),
    .SAMPLE_WIDTH(SAMPLE_WIDTH), .AW(AW)
  ) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .size_x(size_x), .size_y(size_y), .size_z(size_z),
    .q_valid(q_valid), .q_ready(q_ready), .q_query(q_query),
    .q_sh17(q_sh17), .q_addr(q_addr), .q_data(q_data)
  );

  gfg_back #(
    .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z),
    .SAMPLE_WIDTH(SAMPLE_WIDTH), .AW(AW)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_query(q_query),
    .q_sh17(q_sh17), .q_addr(q_addr), .q_data(q_data),
    .inv_step(inv_step), .done(done), .res(res)
  );

endmodule
`default_nettype wire

### sv/gfg_front.sv
`default_nettype none
module gfg_front import gfg_pkg::*; #(
  parameter int MAX_X        = 32,
  parameter int MAX_Y        = 32,
  parameter int MAX_Z        = 32,
  parameter int SAMPLE_WIDTH = 32,
  parameter int AW           = 15
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire gfg_req_t                     req,
  input  wire logic [SIZE_W-1:0]            size_x,
  input  wire logic [SIZE_W-1:0]            size_y,
  input  wire logic [SIZE_W-1:0]            size_z,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output logic                              q_query,
  output logic [2:0]                        q_sh17,
  output logic [5:0][AW-1:0]                q_addr,
  output logic [SAMPLE_WIDTH-1:0]           q_data
);

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] hi;
    logic             sh17;
  } axis_nb_t;

  typedef struct packed {
    logic                    query;
    logic [2:0]              sh17;
    logic [5:0][AW-1:0]      addr;
    logic [SAMPLE_WIDTH-1:0] data;
  } entry_t;

  // Clamp a programmed size into the range the storage supports.
  function automatic logic [CMP_W-1:0] eff_size(input logic [SIZE_W-1:0] s, input int mx);
    if (int'(s) < 2) return CMP_W'(2);
    if (int'(s) > mx) return CMP_W'(mx);
    return CMP_W'(s);
  endfunction

  // Linear store address, x major, z minor.
  function automatic logic [AW-1:0] addr_of(input logic [CMP_W-1:0] x,
                                            input logic [CMP_W-1:0] y,
                                            input logic [CMP_W-1:0] z);
    return AW'((int'(x) * MAX_Y + int'(y)) * MAX_Z + int'(z));
  endfunction

  // Lower and upper neighbor along one axis; edges use the point itself.
  function automatic axis_nb_t axis_nb(input logic [CMP_W-1:0] p, input logic [CMP_W-1:0] n);
    axis_nb_t r;
    logic     first;
    logic     last;
    first  = (p == '0);
    last   = (p == n - CMP_W'(1));
    r.lo   = first ? p : p - CMP_W'(1);
    r.hi   = last ? p : p + CMP_W'(1);
    r.sh17 = !first && !last;
    return r;
  endfunction

  logic [CMP_W-1:0] nx, ny, nz, px, py, pz;
  axis_nb_t         ax, ay, az;
  logic             query_ok, load_ok, push, pop;
  entry_t           ent_in;
  entry_t           fifo [QDEPTH];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  // Classify the incoming word and work out the addresses it needs.
  always_comb begin
    nx = eff_size(size_x, MAX_X);
    ny = eff_size(size_y, MAX_Y);
    nz = eff_size(size_z, MAX_Z);
    px = CMP_W'(req.pos_x);
    py = CMP_W'(req.pos_y);
    pz = CMP_W'(req.pos_z);
    ax = axis_nb(px, nx);
    ay = axis_nb(py, ny);
    az = axis_nb(pz, nz);
    query_ok = (px < nx) && (py < ny) && (pz < nz);
    load_ok  = (int'(px) < MAX_X) && (int'(py) < MAX_Y) && (int'(pz) < MAX_Z);
    ent_in.query   = (req.req_type == REQ_QUERY);
    ent_in.sh17    = {az.sh17, ay.sh17, ax.sh17};
    ent_in.addr[0] = (req.req_type == REQ_QUERY) ? addr_of(ax.lo, py, pz) : addr_of(px, py, pz);
    ent_in.addr[1] = addr_of(ax.hi, py, pz);
    ent_in.addr[2] = addr_of(px, ay.lo, pz);
    ent_in.addr[3] = addr_of(px, ay.hi, pz);
    ent_in.addr[4] = addr_of(px, py, az.lo);
    ent_in.addr[5] = addr_of(px, py, az.hi);
    ent_in.data    = SAMPLE_WIDTH'(req.potential);
  end

  assign busy    = (count == 2'(QDEPTH));
  assign push    = start && !busy && ((req.req_type == REQ_QUERY) ? query_ok : load_ok);
  assign q_valid = (count != '0);
  assign pop     = q_valid && q_ready;

  assign q_query = fifo[rd_ptr].query;
  assign q_sh17  = fifo[rd_ptr].sh17;
  assign q_addr  = fifo[rd_ptr].addr;
  assign q_data  = fifo[rd_ptr].data;

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= ent_in;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### sv/gfg_back.sv
`default_nettype none
module gfg_back import gfg_pkg::*; #(
  parameter int MAX_X        = 32,
  parameter int MAX_Y        = 32,
  parameter int MAX_Z        = 32,
  parameter int SAMPLE_WIDTH = 32,
  parameter int AW           = 15
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  wire logic                       q_query,
  input  wire logic [2:0]                 q_sh17,
  input  wire logic [5:0][AW-1:0]         q_addr,
  input  wire logic [SAMPLE_WIDTH-1:0]    q_data,
  input  wire logic [2:0][STEP_W-1:0]     inv_step,
  output logic                            done,
  output gfg_res_t                        res
);

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int SW    = SAMPLE_WIDTH;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bt;
  } sqrt_t;

  // One step of the bitwise integer square root.
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t r;
    r = s;
    if (s.rem >= s.root + s.bt) begin
      r.rem  = s.rem - (s.root + s.bt);
      r.root = (s.root >> 1) + s.bt;
    end else begin
      r.root = s.root >> 1;
    end
    r.bt = s.bt >> 2;
    return r;
  endfunction

  back_state_t              state, state_next;
  logic [SW-1:0]            mem [DEPTH];
  logic [SW-1:0]            rdata;
  logic [AW-1:0]            raddr;
  logic [5:0][AW-1:0]       addr_r;
  logic [2:0]               sh17_r;
  logic [2:0]               rd_cnt;
  logic [1:0]               axis;
  logic [1:0]               sq_cnt;
  logic [3:0]               sqrt_cnt;
  logic signed [SW-1:0]     sample [6];
  logic signed [SW:0]       diff_w;
  logic [SW:0]              abs_w;
  logic                     neg_r;
  logic [63:0]              absd_r;
  logic [63:0]              prod_hi, prod_lo;
  logic [63:0]              mag_w;
  logic signed [DATA_W-1:0] comp_w;
  logic                     comp_sat;
  logic signed [DATA_W-1:0] field_r [3];
  logic                     sat_r;
  logic [63:0]              sq_r;
  sqrt_t                    sq_state, sq_two;

  assign q_ready = (state == BK_IDLE);
  assign raddr   = (rd_cnt < 3'd6) ? addr_r[rd_cnt] : addr_r[0];

  // Sample store: loads write straight from the queue head.
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && !q_query) mem[q_addr[0]] <= q_data;
    rdata <= mem[raddr];
  end

  // Difference, rounding and clipping for the current axis.
  always_comb begin
    diff_w = (SW+1)'(sample[{axis, 1'b1}]) - (SW+1)'(sample[{axis, 1'b0}]);
    abs_w  = diff_w[SW] ? (SW+1)'(-diff_w) : (SW+1)'(diff_w);
    if (prod_hi >= (64'd1 << 20)) begin
      mag_w = 64'd1 << 40;
    end else if (sh17_r[axis]) begin
      mag_w = (prod_hi << 15) + (prod_lo >> 17) + 64'(prod_lo[16]);
    end else begin
      mag_w = (prod_hi << 16) + (prod_lo >> 16) + 64'(prod_lo[15]);
    end
    comp_sat = 1'b0;
    if (neg_r) begin
      if (mag_w > (64'd1 << 31)) begin
        comp_sat = 1'b1;
        comp_w   = 32'sh8000_0000;
      end else begin
        comp_w = 32'(64'd0 - mag_w);
      end
    end else begin
      if (mag_w > 64'h7FFF_FFFF) begin
        comp_sat = 1'b1;
        comp_w   = 32'sh7FFF_FFFF;
      end else begin
        comp_w = 32'(mag_w);
      end
    end
    sq_two = sqrt_step(sqrt_step(sq_state));
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (q_valid && q_query) state_next = BK_READ;
      BK_READ:   if (rd_cnt == 3'd6) state_next = BK_DIFF;
      BK_DIFF:   state_next = BK_MUL;
      BK_MUL:    state_next = BK_SCALE;
      BK_SCALE:  state_next = (axis == 2'd2) ? BK_SQUARE : BK_DIFF;
      BK_SQUARE: if (sq_cnt == 2'd3) state_next = BK_SQRT;
      BK_SQRT:   if (sqrt_cnt == 4'd15) state_next = BK_DONE;
      BK_DONE:   state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        addr_r <= q_addr;
        sh17_r <= q_sh17;
        rd_cnt <= '0;
        axis   <= '0;
        sat_r  <= 1'b0;
      end
      BK_READ: begin
        if (rd_cnt != '0) sample[rd_cnt - 3'd1] <= $signed(rdata);
        rd_cnt <= rd_cnt + 3'd1;
      end
      BK_DIFF: begin
        neg_r  <= (diff_w > 0);
        absd_r <= 64'(abs_w);
      end
      BK_MUL: begin
        prod_hi <= absd_r[63:32] * inv_step[axis];
        prod_lo <= absd_r[31:0] * inv_step[axis];
      end
      BK_SCALE: begin
        field_r[axis] <= comp_w;
        sat_r         <= sat_r | comp_sat;
        axis          <= axis + 2'd1;
        sq_cnt        <= '0;
        sq_state.rem  <= '0;
      end
      BK_SQUARE: begin
        if (sq_cnt != 2'd3) sq_r <= field_r[sq_cnt] * field_r[sq_cnt];
        if (sq_cnt != '0) sq_state.rem <= sq_state.rem + sq_r;
        sq_state.root <= '0;
        sq_state.bt   <= 64'd1 << 62;
        sq_cnt        <= sq_cnt + 2'd1;
        sqrt_cnt      <= '0;
      end
      BK_SQRT: begin
        sq_state <= sq_two;
        sqrt_cnt <= sqrt_cnt + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // Result word, shown for the one cycle of the done state.
  assign done                = (state == BK_DONE);
  assign res.field_x         = field_r[0];
  assign res.field_y         = field_r[1];
  assign res.field_z         = field_r[2];
  assign res.field_magnitude = sq_state.root[31:0];
  assign res.saturated       = sat_r;

endmodule
`default_nettype wire
